// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHECK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lift_seq_pkg.sv =====
package lift_seq_pkg;

  localparam logic [2:0] ST_STOPPED  = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_DOWN     = 3'd2;
  localparam logic [2:0] ST_CLOSING  = 3'd3;
  localparam logic [2:0] ST_UP       = 3'd4;
  localparam logic [2:0] ST_DROPPING = 3'd5;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_DROP  = 2'd3;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_OPEN  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  localparam logic [2:0] REG_POS_UP        = 3'd0;
  localparam logic [2:0] REG_POS_MEDIUM_UP = 3'd1;
  localparam logic [2:0] REG_POS_DOWN      = 3'd2;
  localparam logic [2:0] REG_MOTION_TOL    = 3'd3;
  localparam logic [2:0] REG_CLOSE_TIME    = 3'd4;
  localparam logic [2:0] REG_MAX_ITEMS     = 3'd5;

  localparam logic signed [15:0] POS_UP_RST        = 16'sd475;
  localparam logic signed [15:0] POS_MEDIUM_UP_RST = 16'sd55;
  localparam logic signed [15:0] POS_DOWN_RST      = 16'sd25;
  localparam logic [15:0]        MOTION_TOL_RST    = 16'd8;
  localparam logic [31:0]        CLOSE_TIME_RST    = 32'd100000;
  localparam logic [2:0]         MAX_ITEMS_RST     = 3'd4;

  typedef struct packed {
    logic signed [15:0] pos_up;
    logic signed [15:0] pos_medium_up;
    logic signed [15:0] pos_down;
    logic [15:0]        motion_tolerance;
    logic [31:0]        close_time_us;
    logic [2:0]         max_items;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         action;
    logic               presence;
    logic signed [31:0] encoder_pos;
    logic [31:0]        now_us;
  } item_t;

  typedef struct packed {
    logic               setpoint_valid;
    logic signed [15:0] setpoint;
    logic [1:0]         hand_cmd;
    logic [1:0]         guide_cmd;
    logic [2:0]         fsm_state;
    logic [2:0]         item_count;
    logic               is_stopped;
    logic               is_empty;
    logic               is_full;
  } res_t;

  function automatic logic motion_done(logic signed [15:0] tgt,
                                       logic signed [31:0] enc,
                                       logic [15:0] tol);
    logic signed [32:0] diff;
    logic [32:0]        mag;
    diff = 33'(tgt) - 33'(enc);
    mag  = diff[32] ? 33'(-diff) : 33'(diff);
    return mag <= {17'd0, tol};
  endfunction

endpackage

// ===== rtl/lift_actuator_sequencer.sv =====
// Throughput: one item per cycle unless the output stalls (out_valid held
// with out_ready low); the tick update is one pass of the state machine
// between the input register and the result register.
// Reset (rst, synchronous): state stopped, no pending command, count zero,
// configuration registers back to their defaults, both pipeline stages empty.
`include "assert_macros.svh"

module lift_actuator_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic               presence,
  input  logic signed [31:0] encoder_pos,
  input  logic [31:0]        now_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               setpoint_valid,
  output logic signed [15:0] setpoint,
  output logic [1:0]         hand_cmd,
  output logic [1:0]         guide_cmd,
  output logic [2:0]         fsm_state,
  output logic [2:0]         item_count,
  output logic               is_stopped,
  output logic               is_empty,
  output logic               is_full
);

  lift_seq_pkg::cfg_t  cfg;
  lift_seq_pkg::item_t item_q;
  lift_seq_pkg::res_t  res;
  logic                item_valid;
  logic                step;

  assign step     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.action      <= action;
      item_q.presence    <= presence;
      item_q.encoder_pos <= encoder_pos;
      item_q.now_us      <= now_us;
    end
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) item_valid <= in_valid;
      if (step) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  lift_seq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lift_seq_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item_q),
    .cfg  (cfg),
    .res  (res)
  );

  assign setpoint_valid = res.setpoint_valid;
  assign setpoint       = res.setpoint;
  assign hand_cmd       = res.hand_cmd;
  assign guide_cmd      = res.guide_cmd;
  assign fsm_state      = res.fsm_state;
  assign item_count     = res.item_count;
  assign is_stopped     = res.is_stopped;
  assign is_empty       = res.is_empty;
  assign is_full        = res.is_full;

  `CHECK_NEXT(a_stop_forces_stopped, step && item_q.action == lift_seq_pkg::CMD_STOP, out_valid && fsm_state == lift_seq_pkg::ST_STOPPED, "stop item did not end stopped")
  `CHECK_IMPL(a_no_setpoint_zero, out_valid && !setpoint_valid, setpoint == 16'sd0, "setpoint not zero without valid")
  `CHECK_IMPL(a_guide_close_idle, out_valid && guide_cmd == lift_seq_pkg::ACT_CLOSE, fsm_state == lift_seq_pkg::ST_IDLE, "guide close outside start")
  `CHECK_NEXT(a_accept_loads_stage, in_valid && in_ready, item_valid, "accepted item not held")

endmodule

// ===== rtl/lift_seq_cfg.sv =====
module lift_seq_cfg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [31:0]             cfg_wdata,
  output lift_seq_pkg::cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_up           <= lift_seq_pkg::POS_UP_RST;
      cfg.pos_medium_up    <= lift_seq_pkg::POS_MEDIUM_UP_RST;
      cfg.pos_down         <= lift_seq_pkg::POS_DOWN_RST;
      cfg.motion_tolerance <= lift_seq_pkg::MOTION_TOL_RST;
      cfg.close_time_us    <= lift_seq_pkg::CLOSE_TIME_RST;
      cfg.max_items        <= lift_seq_pkg::MAX_ITEMS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lift_seq_pkg::REG_POS_UP:        cfg.pos_up           <= cfg_wdata[15:0];
        lift_seq_pkg::REG_POS_MEDIUM_UP: cfg.pos_medium_up    <= cfg_wdata[15:0];
        lift_seq_pkg::REG_POS_DOWN:      cfg.pos_down         <= cfg_wdata[15:0];
        lift_seq_pkg::REG_MOTION_TOL:    cfg.motion_tolerance <= cfg_wdata[15:0];
        lift_seq_pkg::REG_CLOSE_TIME:    cfg.close_time_us    <= cfg_wdata;
        lift_seq_pkg::REG_MAX_ITEMS:     cfg.max_items        <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/lift_seq_core.sv =====
module lift_seq_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  lift_seq_pkg::item_t item,
  input  lift_seq_pkg::cfg_t  cfg,
  output lift_seq_pkg::res_t  res
);

  typedef enum logic [2:0] {
    STOPPED  = lift_seq_pkg::ST_STOPPED,
    IDLE     = lift_seq_pkg::ST_IDLE,
    DOWN     = lift_seq_pkg::ST_DOWN,
    CLOSING  = lift_seq_pkg::ST_CLOSING,
    UP       = lift_seq_pkg::ST_UP,
    DROPPING = lift_seq_pkg::ST_DROPPING
  } state_t;

  state_t             state, state_next;
  logic [1:0]         pending, pending_next;
  logic [2:0]         held_count, held_count_next;
  logic [31:0]        close_start_us, close_start_us_next;
  logic               target_is_medium, target_is_medium_next;
  lift_seq_pkg::res_t res_next;

  always_comb begin
    logic               sp_valid;
    logic signed [15:0] sp;
    logic [1:0]         hand;
    logic [1:0]         guide;
    logic               below_max;
    logic signed [15:0] up_tgt;
    logic [31:0]        elapsed;
    state_t             cur;

    sp_valid  = 1'b0;
    sp        = '0;
    hand      = lift_seq_pkg::ACT_NONE;
    guide     = lift_seq_pkg::ACT_NONE;
    below_max = held_count < cfg.max_items;
    up_tgt    = target_is_medium ? cfg.pos_medium_up : cfg.pos_up;
    elapsed   = item.now_us - close_start_us;

    pending_next          = (item.action != lift_seq_pkg::CMD_NONE) ? item.action : pending;
    held_count_next       = held_count;
    close_start_us_next   = close_start_us;
    target_is_medium_next = target_is_medium;
    cur                   = state;

    if (pending_next == lift_seq_pkg::CMD_STOP) begin
      cur          = STOPPED;
      pending_next = lift_seq_pkg::CMD_NONE;
    end
    state_next = cur;

    unique case (cur)
      STOPPED: begin
        if (pending_next == lift_seq_pkg::CMD_START) begin
          guide        = lift_seq_pkg::ACT_CLOSE;
          state_next   = IDLE;
          pending_next = lift_seq_pkg::CMD_NONE;
        end
      end
      IDLE: begin
        if (pending_next == lift_seq_pkg::CMD_DROP) begin
          sp_valid     = 1'b1;
          sp           = cfg.pos_down;
          state_next   = DROPPING;
          pending_next = lift_seq_pkg::CMD_NONE;
        end else if (item.presence && below_max) begin
          hand       = lift_seq_pkg::ACT_OPEN;
          sp_valid   = 1'b1;
          sp         = cfg.pos_down;
          state_next = DOWN;
        end
      end
      DOWN: begin
        if (lift_seq_pkg::motion_done(cfg.pos_down, item.encoder_pos,
                                      cfg.motion_tolerance)) begin
          hand                = lift_seq_pkg::ACT_CLOSE;
          close_start_us_next = item.now_us;
          if (below_max) held_count_next = held_count + 3'd1;
          state_next          = CLOSING;
        end
      end
      CLOSING: begin
        if (elapsed >= cfg.close_time_us) begin
          target_is_medium_next = !below_max;
          sp_valid              = 1'b1;
          sp                    = below_max ? cfg.pos_up : cfg.pos_medium_up;
          state_next            = UP;
        end
      end
      UP: begin
        if (lift_seq_pkg::motion_done(up_tgt, item.encoder_pos, cfg.motion_tolerance))
          state_next = IDLE;
      end
      DROPPING: begin
        if (lift_seq_pkg::motion_done(cfg.pos_down, item.encoder_pos,
                                      cfg.motion_tolerance)) begin
          hand            = lift_seq_pkg::ACT_OPEN;
          guide           = lift_seq_pkg::ACT_OPEN;
          state_next      = STOPPED;
          held_count_next = '0;
        end
      end
      default: state_next = STOPPED;
    endcase

    res_next.setpoint_valid = sp_valid;
    res_next.setpoint       = sp;
    res_next.hand_cmd       = hand;
    res_next.guide_cmd      = guide;
    res_next.fsm_state      = state_next;
    res_next.item_count     = held_count_next;
    res_next.is_stopped     = state_next == STOPPED;
    res_next.is_empty       = held_count_next == '0;
    res_next.is_full        = held_count_next >= cfg.max_items;
  end

  always_ff @(posedge clk) begin
    if (step) res <= res_next;
    if (rst) begin
      state            <= STOPPED;
      pending          <= lift_seq_pkg::CMD_NONE;
      held_count       <= '0;
      close_start_us   <= '0;
      target_is_medium <= 1'b0;
    end else if (step) begin
      state            <= state_next;
      pending          <= pending_next;
      held_count       <= held_count_next;
      close_start_us   <= close_start_us_next;
      target_is_medium <= target_is_medium_next;
    end
  end

endmodule
